>>> hw/rtl/tsdp_pkg.sv
package tsdp_pkg;

    // Geometry defaults and parameter defaults
    localparam int MAX_COLS_DEF = 128;
    localparam int MAX_ROWS_DEF = 64;
    localparam int DEFAULT_COLS = 80;
    localparam int DEFAULT_ROWS = 25;

    // Attribute bit that swaps foreground and background
    localparam int REVERSE_BIT = 2;

    // Stream widths
    localparam int S_DATA_W   = 40;
    localparam int M_DATA_W   = 32;
    localparam int CELL_W     = 24;
    localparam int CFG_DATA_W = 8;

    // Command kinds carried in m_tuser
    localparam logic CMD_PAINT  = 1'b0;
    localparam logic CMD_CURSOR = 1'b1;

    // Configuration register indexes
    localparam logic CFG_SCREEN_COLS = 1'b0;
    localparam logic CFG_SCREEN_ROWS = 1'b1;

    // One cell plus cursor info, held between lookup and compare
    typedef struct packed {
        logic [CELL_W-1:0] cell_data; // char | fg<<8 | bg<<12 | attr<<16
        logic [5:0]        row;
        logic [6:0]        col;
        logic              last;      // last cell of the pass
        logic              repaint;   // repaint regardless of the cache
        logic [5:0]        cur_row;
        logic [6:0]        cur_col;
        logic              cur_vis;
    } cell_item_t;

endpackage

>>> hw/rtl/text_screen_diff_painter.sv
// Text screen diff painter. Cells arrive on the s_ stream in row-major order, screen_rows by
// screen_cols per pass. Each cell is looked up in an on-chip cache (MAX_COLS * MAX_ROWS entries,
// 24 bits, one read and one write port) and leaves as a paint command when it differs from what
// was painted last, while the cache is invalid, or during a full-redraw pass; after the last cell
// a cursor command follows. Commands reach m_ through the lookup stage and the output register.
// The block takes one item per cycle unless m_ stalls; the last cell of a pass, when it is also
// repainted, is held until its paint and cursor commands leave in turn through the single output
// register. Writing either geometry register invalidates the cache and restarts the pass; the
// cache needs no clearing pass, since it is only compared against once a whole pass has written it.
module text_screen_diff_painter
    import tsdp_pkg::*;
#(
    parameter int MAX_COLS = MAX_COLS_DEF,
    parameter int MAX_ROWS = MAX_ROWS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Input cells
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // cell_char[7:0], cell_fg[11:8], cell_bg[15:12], cell_attr[23:16], full_redraw[24],
    // cursor_col[31:25], cursor_row[37:32], cursor_visible[38], zero pad[39]
    input  logic [S_DATA_W-1:0]   s_tdata,
    // Commands
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // target_row[5:0], target_col[12:6], paint_char[20:13], paint_colour[28:21],
    // show_cursor[29], zero pad[31:30]
    output logic [M_DATA_W-1:0]   m_tdata,
    output logic                  m_tuser,  // command_kind[0]
    output logic                  m_tlast,  // last_of_run
    // Configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int COLW  = $clog2(MAX_COLS + 1);
    localparam int ROWW  = $clog2(MAX_ROWS + 1);
    localparam int CCW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RCW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COLS_RST = (DEFAULT_COLS > MAX_COLS) ? MAX_COLS : DEFAULT_COLS;
    localparam int ROWS_RST = (DEFAULT_ROWS > MAX_ROWS) ? MAX_ROWS : DEFAULT_ROWS;

    // Geometry and pass state
    logic [COLW-1:0] cols_reg, cols_next;
    logic [ROWW-1:0] rows_reg, rows_next;
    logic [CCW-1:0]  col_reg, col_next;
    logic [RCW-1:0]  row_reg, row_next;
    logic            valid_cache_reg, valid_cache_next;
    logic            pass_full_reg, pass_full_next;

    // Lookup stage
    logic            s1_valid_reg;
    cell_item_t      s1_reg;
    logic [AW-1:0]   s1_addr_reg;
    logic            s1_painted_reg;
    logic            fwd_reg;
    logic [CELL_W-1:0] fwd_data_reg;
    logic [CELL_W-1:0] rd_data_reg;
    logic [CELL_W-1:0] cache_mem [DEPTH];

    // Output register
    logic                m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg;
    logic                m_kind_reg;
    logic                m_last_reg;

    logic            s_accept, cfg_accept;
    logic            wrap, first, full_eff, last, force_paint;
    logic [CCW-1:0]  c_eff;
    logic [RCW-1:0]  r_eff;
    logic [AW-1:0]   addr0;
    logic [CELL_W-1:0] cached;
    logic            need_paint, paint_pend, cursor_pend, out_free;
    logic            move_paint, move_cursor, s1_done;
    logic [8:0]      geo_c;
    logic [7:0]      geo_r;
    logic [7:0]      colour;

    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign s_accept   = s_tvalid && s_tready;

    // Position of the incoming cell and its pass flags
    always_comb begin
        wrap = ((COLW+1)'(col_reg) >= (COLW+1)'(cols_reg))
            || ((ROWW+1)'(row_reg) >= (ROWW+1)'(rows_reg));
        c_eff = wrap ? '0 : col_reg;
        r_eff = wrap ? '0 : row_reg;
        first = (c_eff == '0) && (r_eff == '0);
        full_eff = first ? s_tdata[24] : pass_full_reg;
        last = ((ROWW+1)'(r_eff) + (ROWW+1)'(1) == (ROWW+1)'(rows_reg))
            && ((COLW+1)'(c_eff) + (COLW+1)'(1) == (COLW+1)'(cols_reg));
        force_paint = !valid_cache_reg || full_eff;
        addr0 = AW'(AW'(r_eff) * AW'(MAX_COLS) + AW'(c_eff));
    end

    // Fit configuration values to the supported geometry
    always_comb begin
        geo_c = (cfg_data == '0) ? 9'(DEFAULT_COLS) : 9'(cfg_data);
        if (32'(geo_c) > MAX_COLS) begin
            geo_c = 9'(MAX_COLS);
        end
        geo_r = (cfg_data[6:0] == '0) ? 8'(DEFAULT_ROWS) : 8'(cfg_data[6:0]);
        if (32'(geo_r) > MAX_ROWS) begin
            geo_r = 8'(MAX_ROWS);
        end
    end

    // Next pass state: config restarts the pass, an item advances it
    always_comb begin
        cols_next        = cols_reg;
        rows_next        = rows_reg;
        col_next         = col_reg;
        row_next         = row_reg;
        valid_cache_next = valid_cache_reg;
        pass_full_next   = pass_full_reg;
        if (cfg_accept) begin
            unique case (cfg_index)
                CFG_SCREEN_COLS: cols_next = COLW'(geo_c);
                CFG_SCREEN_ROWS: rows_next = ROWW'(geo_r);
                default: ;
            endcase
            col_next         = '0;
            row_next         = '0;
            valid_cache_next = 1'b0;
            pass_full_next   = 1'b0;
        end else if (s_accept) begin
            if (last) begin
                valid_cache_next = 1'b1;
                pass_full_next   = 1'b0;
                col_next         = '0;
                row_next         = '0;
            end else begin
                pass_full_next = full_eff;
                if ((COLW+1)'(c_eff) + (COLW+1)'(1) >= (COLW+1)'(cols_reg)) begin
                    col_next = '0;
                    row_next = r_eff + RCW'(1);
                end else begin
                    col_next = c_eff + CCW'(1);
                    row_next = r_eff;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_reg        <= COLW'(COLS_RST);
            rows_reg        <= ROWW'(ROWS_RST);
            col_reg         <= '0;
            row_reg         <= '0;
            valid_cache_reg <= 1'b0;
            pass_full_reg   <= 1'b0;
        end else begin
            cols_reg        <= cols_next;
            rows_reg        <= rows_next;
            col_reg         <= col_next;
            row_reg         <= row_next;
            valid_cache_reg <= valid_cache_next;
            pass_full_reg   <= pass_full_next;
        end
    end

    // Compare against the cache, forwarding a write made at the read edge
    always_comb begin
        cached      = fwd_reg ? fwd_data_reg : rd_data_reg;
        need_paint  = s1_reg.repaint || (cached != s1_reg.cell_data);
        paint_pend  = s1_valid_reg && need_paint && !s1_painted_reg;
        cursor_pend = s1_valid_reg && s1_reg.last;
        out_free    = !m_valid_reg || m_tready;
        move_paint  = paint_pend && out_free;
        move_cursor = !paint_pend && cursor_pend && out_free;
        if (!s1_valid_reg) begin
            s1_done = 1'b1;
        end else if (paint_pend) begin
            s1_done = out_free && !cursor_pend;
        end else begin
            s1_done = !cursor_pend || out_free;
        end
    end

    assign s_tready = s1_done;

    // Hold the cell while its commands drain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg   <= 1'b0;
            s1_painted_reg <= 1'b0;
            fwd_reg        <= 1'b0;
        end else if (s_accept) begin
            s1_valid_reg   <= 1'b1;
            s1_painted_reg <= 1'b0;
            fwd_reg        <= move_paint && (s1_addr_reg == addr0);
        end else begin
            if (s1_done) begin
                s1_valid_reg <= 1'b0;
            end
            if (move_paint) begin
                s1_painted_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_reg.cell_data <= s_tdata[CELL_W-1:0];
            s1_reg.row       <= 6'(r_eff);
            s1_reg.col       <= 7'(c_eff);
            s1_reg.last      <= last;
            s1_reg.repaint   <= force_paint;
            s1_reg.cur_col   <= s_tdata[31:25];
            s1_reg.cur_row   <= s_tdata[37:32];
            s1_reg.cur_vis   <= s_tdata[38];
            s1_addr_reg      <= addr0;
            fwd_data_reg     <= s1_reg.cell_data;
        end
    end

    // Painted cache: write on paint, read on accept
    always_ff @(posedge aclk) begin
        if (move_paint) begin
            cache_mem[s1_addr_reg] <= s1_reg.cell_data;
        end
        if (s_accept) begin
            rd_data_reg <= cache_mem[addr0];
        end
    end

    // Pack the colour byte, swapped for reverse video
    assign colour = s1_reg.cell_data[16 + REVERSE_BIT]
                  ? {s1_reg.cell_data[11:8], s1_reg.cell_data[15:12]}
                  : {s1_reg.cell_data[15:12], s1_reg.cell_data[11:8]};

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (move_paint || move_cursor) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (move_paint) begin
            m_kind_reg <= CMD_PAINT;
            m_last_reg <= !s1_reg.last;
            m_data_reg <= {2'b00, 1'b0, colour, s1_reg.cell_data[7:0], s1_reg.col, s1_reg.row};
        end else if (move_cursor) begin
            m_kind_reg <= CMD_CURSOR;
            m_last_reg <= 1'b1;
            m_data_reg <= {2'b00, s1_reg.cur_vis, 8'h00, 8'h00, s1_reg.cur_col, s1_reg.cur_row};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

    // A cursor command always closes its run
    a_cursor_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == CMD_CURSOR) |-> m_tlast)
        else $error("cursor command without last_of_run");

    // A paint of the last cell is followed directly by the cursor command
    a_paint_then_cursor: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tuser == CMD_PAINT && !m_tlast)
        |=> (m_tvalid && m_tuser == CMD_CURSOR))
        else $error("cursor command missing after last paint");

    // Position counters stay inside the configured screen
    a_pos_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ((COLW+1)'(col_reg) < (COLW+1)'(cols_reg))
        && ((ROWW+1)'(row_reg) < (ROWW+1)'(rows_reg)))
        else $error("position counter outside the screen");

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import tsdp_pkg::*;

    localparam int LIMIT_CYCLES = 500000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES = 400;
    localparam int SCREEN_CELLS = MAX_COLS_DEF * MAX_ROWS_DEF;
    localparam int REPORT_LIMIT = 10;

    // One command as it leaves the block
    typedef struct packed {
        logic       kind;
        logic [5:0] row;
        logic [6:0] col;
        logic [7:0] ch;
        logic [7:0] colour;
        logic       show;
        logic       last;
    } screen_cmd_t;

    typedef enum logic {STEP_CELL, STEP_REG} step_kind_t;

    // One row of the directed table; register rows carry {index, value} in data[8:0]
    typedef struct packed {
        step_kind_t  kind;
        logic [39:0] data;
        logic        typed;
        logic [1:0]  n_typed;
        screen_cmd_t cmd_a;
        screen_cmd_t cmd_b;
    } step_t;

    localparam screen_cmd_t NO_CMD = '0;

    logic                  aclk;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic                  cfg_index = 1'b0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Predicted state of the painter
    logic [CELL_W-1:0] painted_img [0:SCREEN_CELLS-1];
    logic              painted_valid;
    logic              redraw_pass;
    int                geo_cols;
    int                geo_rows;
    int                scan_row;
    int                scan_col;

    // Screen contents that the stimulus keeps repainting
    logic [CELL_W-1:0] screen_img [0:SCREEN_CELLS-1];

    screen_cmd_t expected_cmds [$];
    step_t       directed_steps [$];
    int          mismatch_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_requests = 0;
    int          holds_seen = 0;
    int          hold_left = 0;
    int          cycle_count = 0;
    screen_cmd_t seen_cmd;
    screen_cmd_t wanted_cmd;

    text_screen_diff_painter i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic int fit_geometry(input int v, input int dflt, input int maxv);
        int g;
        g = (v == 0) ? dflt : v;
        return (g > maxv) ? maxv : g;
    endfunction

    function automatic logic [39:0] cell_item(input logic [7:0] ch, input logic [3:0] fg,
                                              input logic [3:0] bg, input logic [7:0] attr,
                                              input logic redraw, input logic [6:0] ccol,
                                              input logic [5:0] crow, input logic cvis);
        return {1'b0, cvis, crow, ccol, redraw, attr, bg, fg, ch};
    endfunction

    function automatic screen_cmd_t paint_cmd(input logic [5:0] row, input logic [6:0] col,
                                              input logic [7:0] ch, input logic [7:0] colour,
                                              input logic last);
        return '{kind: CMD_PAINT, row: row, col: col, ch: ch, colour: colour,
                 show: 1'b0, last: last};
    endfunction

    function automatic screen_cmd_t cursor_cmd(input logic [5:0] row, input logic [6:0] col,
                                               input logic show);
        return '{kind: CMD_CURSOR, row: row, col: col, ch: 8'h00, colour: 8'h00,
                 show: show, last: 1'b1};
    endfunction

    function automatic step_t typed_step(input logic [39:0] d, input logic [1:0] n,
                                         input screen_cmd_t a, input screen_cmd_t b);
        return '{kind: STEP_CELL, data: d, typed: 1'b1, n_typed: n, cmd_a: a, cmd_b: b};
    endfunction

    function automatic step_t free_step(input logic [39:0] d);
        return '{kind: STEP_CELL, data: d, typed: 1'b0, n_typed: 2'd0,
                 cmd_a: NO_CMD, cmd_b: NO_CMD};
    endfunction

    function automatic step_t reg_step(input logic idx, input logic [7:0] val);
        return '{kind: STEP_REG, data: {31'd0, idx, val}, typed: 1'b0, n_typed: 2'd0,
                 cmd_a: NO_CMD, cmd_b: NO_CMD};
    endfunction

    function automatic string cmd_text(input screen_cmd_t c);
        return $sformatf("kind %0d row %0d col %0d char %02h colour %02h show %0d last %0d",
                         c.kind, c.row, c.col, c.ch, c.colour, c.show, c.last);
    endfunction

    // Restart the pass and apply a geometry write
    task automatic apply_geometry(input logic idx, input logic [7:0] val);
        if (idx == CFG_SCREEN_COLS) begin
            geo_cols = fit_geometry(int'(val), DEFAULT_COLS, MAX_COLS_DEF);
        end else begin
            geo_rows = fit_geometry(int'(val[6:0]), DEFAULT_ROWS, MAX_ROWS_DEF);
        end
        painted_valid = 1'b0;
        redraw_pass = 1'b0;
        scan_row = 0;
        scan_col = 0;
    endtask

    // Work out the commands that one cell causes, and advance the scan position
    task automatic predict_cell(input logic [39:0] d, output screen_cmd_t c0,
                                output screen_cmd_t c1, output int n);
        logic [3:0]        fg;
        logic [3:0]        bg;
        logic [7:0]        attr;
        logic [CELL_W-1:0] cell_word;
        int                slot;
        logic              at_end;
        screen_cmd_t       cur;
        fg = d[11:8];
        bg = d[15:12];
        attr = d[23:16];
        cell_word = d[CELL_W-1:0];
        c0 = NO_CMD;
        c1 = NO_CMD;
        n = 0;
        if (scan_row >= geo_rows || scan_col >= geo_cols) begin
            scan_row = 0;
            scan_col = 0;
        end
        if (scan_row == 0 && scan_col == 0) begin
            redraw_pass = d[24];
        end
        slot = scan_row * MAX_COLS_DEF + scan_col;
        at_end = (scan_row + 1 == geo_rows) && (scan_col + 1 == geo_cols);
        // paint on a difference, an invalid cache or a full redraw
        if (!painted_valid || redraw_pass || painted_img[slot] != cell_word) begin
            c0 = paint_cmd(scan_row[5:0], scan_col[6:0], d[7:0],
                           attr[REVERSE_BIT] ? {fg, bg} : {bg, fg}, !at_end);
            painted_img[slot] = cell_word;
            n = 1;
        end
        if (at_end) begin
            painted_valid = 1'b1;
            redraw_pass = 1'b0;
            cur = cursor_cmd(d[37:32], d[31:25], d[38]);
            if (n == 0) begin
                c0 = cur;
            end else begin
                c1 = cur;
            end
            n = n + 1;
            scan_row = 0;
            scan_col = 0;
        end else begin
            scan_col = scan_col + 1;
            if (scan_col >= geo_cols) begin
                scan_col = 0;
                scan_row = scan_row + 1;
            end
        end
    endtask

    // Offer one cell, with random idle cycles first, and queue its commands once taken
    task automatic offer_cell(input logic [39:0] d, input logic typed, input logic [1:0] n_typed,
                              input screen_cmd_t typed_a, input screen_cmd_t typed_b);
        screen_cmd_t pa;
        screen_cmd_t pb;
        int          np;
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        do @(posedge aclk); while (!s_tready);
        predict_cell(d, pa, pb, np);
        if (typed) begin
            np = int'(n_typed);
            pa = typed_a;
            pb = typed_b;
        end
        if (np > 0) expected_cmds.push_back(pa);
        if (np > 1) expected_cmds.push_back(pb);
    endtask

    // Drop valid, drain every expected command, then let the pipeline empty
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_cmds.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        apply_geometry(idx, val);
    endtask

    // Configure a geometry, then stream repeated screens with random edits
    task automatic run_phase(input int p);
        logic [7:0]  cols_w;
        logic [7:0]  rows_w;
        int          n_cells;
        int          n_items;
        int          pos;
        int          i;
        int          k;
        logic        noisy;
        logic        redraw;
        logic [13:0] cursor_bits;
        logic [39:0] d;
        case (p)
            1:  begin cols_w = 8'd1;   rows_w = 8'd1;   end
            3:  begin cols_w = 8'd128; rows_w = 8'd1;   end
            5:  begin cols_w = 8'd1;   rows_w = 8'd64;  end
            7:  begin cols_w = 8'd0;   rows_w = 8'd1;   end
            9:  begin cols_w = 8'd1;   rows_w = 8'd0;   end
            11: begin cols_w = 8'd255; rows_w = 8'hC0;  end
            13: begin cols_w = 8'd2;   rows_w = 8'hC5;  end
            default: begin
                cols_w = 8'($urandom_range(1, 8));
                rows_w = 8'($urandom_range(1, 6));
            end
        endcase
        wait_idle();
        write_reg(CFG_SCREEN_COLS, cols_w);
        wait_idle();
        write_reg(CFG_SCREEN_ROWS, rows_w);

        case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
            default: begin send_idle_pct = 6; recv_stall_pct = 6; end
        endcase
        if (p == 4) hold_requests = hold_requests + 1;

        n_cells = geo_cols * geo_rows;
        if (n_cells <= 40) begin
            n_items = (32 / n_cells + 1) * n_cells + $urandom_range(0, n_cells - 1);
        end else if (n_cells <= 128) begin
            n_items = n_cells + n_cells / 2 + $urandom_range(0, 15);
        end else begin
            n_items = 80;
        end
        for (k = 0; k < n_cells; k++) screen_img[k] = CELL_W'($urandom);

        pos = 0;
        noisy = 1'b0;
        redraw = 1'b0;
        for (i = 0; i < n_items; i++) begin
            // pick the flavor of each pass on its first cell
            if (pos == 0) begin
                noisy = ($urandom_range(0, 5) == 0);
                redraw = ($urandom_range(0, 7) == 0);
            end
            if (noisy || $urandom_range(0, 7) == 0) screen_img[pos] = CELL_W'($urandom);
            cursor_bits = 14'($urandom);
            d = {1'b0, cursor_bits, (pos == 0) ? redraw : 1'($urandom), screen_img[pos]};
            offer_cell(d, 1'b0, 2'd0, NO_CMD, NO_CMD);
            pos = (pos + 1 == n_cells) ? 0 : pos + 1;
        end
    endtask

    // Take commands and compare them with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            seen_cmd = '{kind: m_tuser, row: m_tdata[5:0], col: m_tdata[12:6],
                         ch: m_tdata[20:13], colour: m_tdata[28:21], show: m_tdata[29],
                         last: m_tlast};
            if (expected_cmds.size() == 0) begin
                mismatch_count = mismatch_count + 1;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected command: %s", cmd_text(seen_cmd));
            end else begin
                wanted_cmd = expected_cmds.pop_front();
                if (seen_cmd != wanted_cmd || m_tdata[31:30] != 2'b00) begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("command mismatch: expected %s, got %s pad %0d",
                                 cmd_text(wanted_cmd), cmd_text(seen_cmd), m_tdata[31:30]);
                end
            end
        end
        // stall at random, or hold off for a long stretch when asked
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (holds_seen != hold_requests) begin
            holds_seen = hold_requests;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // End the run if it hangs
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        int k;
        for (k = 0; k < SCREEN_CELLS; k++) painted_img[k] = '0;
        geo_cols = fit_geometry(DEFAULT_COLS, DEFAULT_COLS, MAX_COLS_DEF);
        geo_rows = fit_geometry(DEFAULT_ROWS, DEFAULT_ROWS, MAX_ROWS_DEF);
        painted_valid = 1'b0;
        redraw_pass = 1'b0;
        scan_row = 0;
        scan_col = 0;

        // cells at the reset geometry, cache still invalid: every cell paints
        directed_steps.push_back(typed_step(
            cell_item(8'h00, 4'h0, 4'h0, 8'h00, 1'b0, 7'd0, 6'd0, 1'b0), 2'd1,
            paint_cmd(6'd0, 7'd0, 8'h00, 8'h00, 1'b1), NO_CMD));
        directed_steps.push_back(typed_step(
            cell_item(8'hFF, 4'hF, 4'h0, 8'h04, 1'b1, 7'd127, 6'd63, 1'b1), 2'd1,
            paint_cmd(6'd0, 7'd1, 8'hFF, 8'hF0, 1'b1), NO_CMD));
        directed_steps.push_back(typed_step(
            cell_item(8'h41, 4'h3, 4'hA, 8'hFB, 1'b0, 7'd0, 6'd0, 1'b0), 2'd1,
            paint_cmd(6'd0, 7'd2, 8'h41, 8'hA3, 1'b1), NO_CMD));
        // 2 x 2 screen, first pass paints all, cursor placed off screen
        directed_steps.push_back(reg_step(CFG_SCREEN_COLS, 8'd2));
        directed_steps.push_back(reg_step(CFG_SCREEN_ROWS, 8'd2));
        directed_steps.push_back(typed_step(
            cell_item(8'h10, 4'h1, 4'h2, 8'h00, 1'b0, 7'd5, 6'd1, 1'b1), 2'd1,
            paint_cmd(6'd0, 7'd0, 8'h10, 8'h21, 1'b1), NO_CMD));
        directed_steps.push_back(typed_step(
            cell_item(8'h11, 4'h1, 4'h2, 8'h00, 1'b0, 7'd0, 6'd0, 1'b0), 2'd1,
            paint_cmd(6'd0, 7'd1, 8'h11, 8'h21, 1'b1), NO_CMD));
        directed_steps.push_back(typed_step(
            cell_item(8'h12, 4'h1, 4'h2, 8'h00, 1'b0, 7'd0, 6'd0, 1'b0), 2'd1,
            paint_cmd(6'd1, 7'd0, 8'h12, 8'h21, 1'b1), NO_CMD));
        directed_steps.push_back(typed_step(
            cell_item(8'h13, 4'h1, 4'h2, 8'h04, 1'b0, 7'd127, 6'd63, 1'b1), 2'd2,
            paint_cmd(6'd1, 7'd1, 8'h13, 8'h12, 1'b0), cursor_cmd(6'd63, 7'd127, 1'b1)));
        // same screen again: nothing repaints, only the cursor
        directed_steps.push_back(typed_step(
            cell_item(8'h10, 4'h1, 4'h2, 8'h00, 1'b0, 7'd9, 6'd9, 1'b1), 2'd0, NO_CMD, NO_CMD));
        directed_steps.push_back(typed_step(
            cell_item(8'h11, 4'h1, 4'h2, 8'h00, 1'b0, 7'd0, 6'd0, 1'b0), 2'd0, NO_CMD, NO_CMD));
        directed_steps.push_back(typed_step(
            cell_item(8'h12, 4'h1, 4'h2, 8'h00, 1'b0, 7'd0, 6'd0, 1'b0), 2'd0, NO_CMD, NO_CMD));
        directed_steps.push_back(typed_step(
            cell_item(8'h13, 4'h1, 4'h2, 8'h04, 1'b0, 7'd0, 6'd0, 1'b0), 2'd1,
            cursor_cmd(6'd0, 7'd0, 1'b0), NO_CMD));
        // one edited cell, redraw flag ignored off the first cell
        directed_steps.push_back(free_step(cell_item(8'h10, 4'h1, 4'h2, 8'h00, 1'b0,
                                                     7'd3, 6'd3, 1'b0)));
        directed_steps.push_back(free_step(cell_item(8'h11, 4'h5, 4'h2, 8'h00, 1'b1,
                                                     7'd3, 6'd3, 1'b0)));
        directed_steps.push_back(free_step(cell_item(8'h12, 4'h1, 4'h2, 8'h00, 1'b0,
                                                     7'd3, 6'd3, 1'b0)));
        directed_steps.push_back(free_step(cell_item(8'h13, 4'h1, 4'h2, 8'h04, 1'b0,
                                                     7'd1, 6'd1, 1'b1)));
        // full redraw pass over an unchanged screen
        directed_steps.push_back(free_step(cell_item(8'h10, 4'h1, 4'h2, 8'h00, 1'b1,
                                                     7'd0, 6'd0, 1'b0)));
        directed_steps.push_back(free_step(cell_item(8'h11, 4'h5, 4'h2, 8'h00, 1'b0,
                                                     7'd0, 6'd0, 1'b0)));
        directed_steps.push_back(free_step(cell_item(8'h12, 4'h1, 4'h2, 8'h00, 1'b0,
                                                     7'd0, 6'd0, 1'b0)));
        directed_steps.push_back(free_step(cell_item(8'h13, 4'h1, 4'h2, 8'h04, 1'b0,
                                                     7'd64, 6'd32, 1'b1)));
        // zero columns take the default, oversize rows saturate
        directed_steps.push_back(reg_step(CFG_SCREEN_COLS, 8'd0));
        directed_steps.push_back(reg_step(CFG_SCREEN_ROWS, 8'hFF));
        directed_steps.push_back(free_step(cell_item(8'h7E, 4'hC, 4'h3, 8'h80, 1'b0,
                                                     7'd0, 6'd0, 1'b0)));
        // oversize columns saturate, zero rows take the default
        directed_steps.push_back(reg_step(CFG_SCREEN_COLS, 8'hFF));
        directed_steps.push_back(reg_step(CFG_SCREEN_ROWS, 8'd0));
        directed_steps.push_back(free_step(cell_item(8'h20, 4'h7, 4'h8, 8'h04, 1'b1,
                                                     7'd0, 6'd0, 1'b0)));
        directed_steps.push_back(free_step(cell_item(8'h21, 4'h8, 4'h7, 8'h00, 1'b0,
                                                     7'd0, 6'd0, 1'b0)));

        // hold reset
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // walk the directed table
        foreach (directed_steps[k]) begin
            if (directed_steps[k].kind == STEP_REG) begin
                wait_idle();
                write_reg(directed_steps[k].data[8], directed_steps[k].data[7:0]);
            end else begin
                offer_cell(directed_steps[k].data, directed_steps[k].typed,
                           directed_steps[k].n_typed, directed_steps[k].cmd_a,
                           directed_steps[k].cmd_b);
            end
        end

        // random screens over a range of geometries and idle patterns
        for (k = 0; k < 14; k++) run_phase(k);

        wait_idle();
        if (mismatch_count == 0 && expected_cmds.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/tsdp_pkg.sv
hw/rtl/text_screen_diff_painter.sv
tb/sv/testbench.sv
